// File: rtl/wres_pkg.sv
package wres_pkg;

  // Command codes carried by a request.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Status codes returned with every result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Fixed widths of the result fields and the request inputs.
  localparam int unsigned OUT_IDX_W = 8;
  localparam int unsigned OUT_CNT_W = 9;
  localparam int unsigned IN_WGT_W  = 16;
  localparam int unsigned RAND_W    = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// File: rtl/weighted_random_entry_selector_core.sv
// Weighted random entry selector (roulette-wheel selection).
// Requests arrive on in_valid/in_ready with a command, a weight and a 32-bit
// random fraction; every request yields exactly one result on out_valid/
// out_ready with a status, an entry index and the entry count after it.
// An add request writes the weight into the table RAM and updates the count
// and the weight total. A clear request zeroes count and total.
// A sample request first scales the fraction by the total in a low and a
// high multiply step, then reads the weight RAM one entry per cycle,
// accumulating the running sum until it exceeds the threshold. The single
// read port of the weight RAM sets the pace of the scan.
// Only one request is in work at a time, but a finished result sits in the
// output register, so the next request is taken while the receiver stalls;
// that request then holds its result until the output register frees up.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result. The RAM itself is not cleared: entries at or above the count are
// never read.
module weighted_random_entry_selector_core #(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_weight,
  input  logic [31:0] in_random_fraction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_selected_index,
  output logic [8:0]  out_entry_count
);

  localparam int unsigned IDX_W   = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W   = $clog2(MAX_ENTRIES + 1);
  // The total of MAX_ENTRIES weights fits in this many bits.
  localparam int unsigned TOTAL_W = IDX_W + WEIGHT_BITS;
  localparam int unsigned HI_W    = (TOTAL_W > 32) ? (TOTAL_W - 32) : 1;

  // Weight table RAM, one write and one registered read port.
  logic [WEIGHT_BITS-1:0] mem [MAX_ENTRIES];
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [WEIGHT_BITS-1:0] wr_data;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [WEIGHT_BITS-1:0] rd_data_r;

  wres_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload registers; no reset needed.
  logic [31:0]        rand_r, rand_nxt;
  logic [63:0]        prod_lo_r, prod_lo_nxt;
  logic [TOTAL_W-1:0] thr_r, thr_nxt;
  logic [TOTAL_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]   iss_cnt_r, iss_cnt_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic [IDX_W-1:0]   res_idx_r, res_idx_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [7:0]         out_idx_r, out_idx_nxt;
  logic [8:0]         out_cnt_r, out_cnt_nxt;

  logic [WEIGHT_BITS-1:0] w_in;
  logic [63:0]            total64;
  logic [HI_W-1:0]        total_hi;
  logic [32+HI_W-1:0]     prod_hi;
  logic [63:0]            thr_full;
  logic [TOTAL_W-1:0]     sum_step;
  logic [31:0]            idx_wide;
  logic [31:0]            cnt_wide;
  logic                   in_acc;

  // Only the low WEIGHT_BITS bits of the request weight are kept.
  always_comb begin
    for (int i = 0; i < WEIGHT_BITS; i++) begin
      w_in[i] = (i < wres_pkg::IN_WGT_W) ? in_weight[i] : 1'b0;
    end
  end

  // Threshold = (r * total) >> 32, split into a low and a high partial product.
  assign total64  = 64'(total_r);
  assign total_hi = total64[32 +: HI_W];
  assign prod_hi  = rand_r * total_hi;
  assign thr_full = 64'(prod_hi) + 64'(prod_lo_r[63:32]);
  assign sum_step = sum_r + TOTAL_W'(rd_data_r);
  assign idx_wide = 32'(res_idx_r);
  assign cnt_wide = 32'(count_r);

  assign in_ready = (state_r == wres_pkg::S_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r;
    rand_nxt       = rand_r;
    prod_lo_nxt    = prod_lo_r;
    thr_nxt        = thr_r;
    sum_nxt        = sum_r;
    iss_cnt_nxt    = iss_cnt_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_cnt_nxt    = out_cnt_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[IDX_W-1:0];
    wr_data        = w_in;
    rd_en          = 1'b0;
    rd_addr        = iss_cnt_r[IDX_W-1:0];

    // The output register drains independently of the request in work.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      wres_pkg::S_IDLE: begin
        if (in_acc) begin
          res_status_nxt = wres_pkg::ST_OK;
          res_idx_nxt    = '0;
          state_nxt      = wres_pkg::S_DONE;
          case (in_cmd)
            wres_pkg::CMD_ADD: begin
              if (count_r >= CNT_W'(MAX_ENTRIES)) begin
                res_status_nxt = wres_pkg::ST_FULL;
              end else begin
                wr_en       = 1'b1;
                res_idx_nxt = count_r[IDX_W-1:0];
                count_nxt   = count_r + CNT_W'(1);
                total_nxt   = total_r + TOTAL_W'(w_in);
              end
            end
            wres_pkg::CMD_SAMPLE: begin
              if (count_r == '0 || total_r == '0) begin
                res_status_nxt = wres_pkg::ST_EMPTY;
              end else begin
                rand_nxt  = in_random_fraction;
                state_nxt = wres_pkg::S_MUL_LO;
              end
            end
            wres_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              total_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      wres_pkg::S_MUL_LO: begin
        prod_lo_nxt = rand_r * total64[31:0];
        state_nxt   = wres_pkg::S_MUL_HI;
      end
      wres_pkg::S_MUL_HI: begin
        thr_nxt     = thr_full[TOTAL_W-1:0];
        sum_nxt     = '0;
        iss_cnt_nxt = '0;
        pend_nxt    = 1'b0;
        state_nxt   = wres_pkg::S_SCAN;
      end
      wres_pkg::S_SCAN: begin
        // Issue the next read while the previous entry's data is summed.
        if (iss_cnt_r < count_r) begin
          rd_en        = 1'b1;
          iss_cnt_nxt  = iss_cnt_r + CNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = iss_cnt_r[IDX_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          sum_nxt = sum_step;
          if (sum_step > thr_r) begin
            res_idx_nxt = pend_idx_r;
            state_nxt   = wres_pkg::S_DONE;
          end
        end else if (iss_cnt_r >= count_r) begin
          // No crossing found; the threshold is below the total, so this is
          // a fallback that picks the last entry.
          res_idx_nxt = IDX_W'(count_r - CNT_W'(1));
          state_nxt   = wres_pkg::S_DONE;
        end
      end
      wres_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = idx_wide[wres_pkg::OUT_IDX_W-1:0];
          out_cnt_nxt    = cnt_wide[wres_pkg::OUT_CNT_W-1:0];
          state_nxt      = wres_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wres_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wres_pkg::S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rand_r       <= rand_nxt;
    prod_lo_r    <= prod_lo_nxt;
    thr_r        <= thr_nxt;
    sum_r        <= sum_nxt;
    iss_cnt_r    <= iss_cnt_nxt;
    pend_r       <= pend_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // Weight RAM. Writes happen only in the idle state and reads only during
  // a scan, so a read never overlaps a write to the same entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_selected_index = out_idx_r;
  assign out_entry_count    = out_cnt_r;

  // The count never runs past the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count exceeds table size");

  // Count and total change only when a request is taken in the idle state.
  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != wres_pkg::S_IDLE) |=> ($stable(count_r) && $stable(total_r)))
    else $error("table state changed while a request was in work");

  // The running sum of a scan stays within the total.
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wres_pkg::S_SCAN) |-> (sum_r <= total_r))
    else $error("running sum exceeds weight total");

  // A successful result names an entry that is held whenever the table is not empty.
  a_idx_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wres_pkg::S_DONE && res_status_r == wres_pkg::ST_OK &&
     count_r != '0) |-> (CNT_W'(res_idx_r) < count_r))
    else $error("selected index outside the held entries");

endmodule
